>>> rtl/ptrk_pkg.sv
package ptrk_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = 25;
    localparam int PROD_W  = 50;
    localparam int NUM_W   = 51;
    localparam int OUT_W   = 26;
    localparam int LEN_W   = 26;
    localparam int SQ_W    = 49;
    localparam int SUM_W   = 50;
    localparam int REM_W   = 52;
    localparam int IDX_W   = 3;

    localparam int DIV_STAGES = OUT_W;
    localparam int DIV_LAT    = DIV_STAGES + 3;
    localparam int FRONT_LAT  = 3;
    localparam int LAT        = FRONT_LAT + DIV_LAT;

    localparam logic [IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_GOAL_X  = 3'd2;
    localparam logic [IDX_W-1:0] REG_GOAL_Y  = 3'd3;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [2:0] {
        SEG_IDLE,
        SEG_SQ,
        SEG_SUM,
        SEG_ITER,
        SEG_ROUND
    } seg_state_t;

    typedef struct packed {
        logic                      busy;
        logic                      degen;
        logic [LEN_W-1:0]          len;
        logic signed [DIFF_W-1:0]  a;
        logic signed [DIFF_W-1:0]  b;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
    } seg_t;

endpackage

>>> rtl/path_line_tracking_error_top.sv
// Throughput: one position per cycle through the multiply and
// bit-per-stage divider pipeline; a stalled valid output holds the whole pipeline.
// After a register write the square-root sequencer holds in_stall until idle.
// Reset (asynchronous, rst_n low): registers zero, length zero, degenerate set.
module path_line_tracking_error_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ptrk_pkg::IDX_W-1:0]          cfg_index,
    input  logic [ptrk_pkg::COORD_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [ptrk_pkg::COORD_W-1:0] pos_x,
    input  logic signed [ptrk_pkg::COORD_W-1:0] pos_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ptrk_pkg::OUT_W-1:0]   cross_track,
    output logic signed [ptrk_pkg::OUT_W-1:0]   along_track,
    output logic                                degenerate
);

    localparam int L = ptrk_pkg::LAT;

    ptrk_pkg::seg_t seg;

    logic adv;
    logic accept;
    logic v_reg [0:L-1];

    logic signed [ptrk_pkg::DIFF_W-1:0] dx_reg, dy_reg;
    logic signed [ptrk_pkg::PROD_W-1:0] ady_reg, bdx_reg, adx_reg, bdy_reg;
    logic signed [ptrk_pkg::NUM_W-1:0]  numc_reg, numa_reg;
    logic signed [ptrk_pkg::OUT_W-1:0]  quo_c, quo_a;

    ptrk_seg u_seg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .seg       (seg)
    );

    assign adv      = !v_reg[L-1] || !out_stall;
    assign in_stall = seg.busy || !adv;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < L; k++)
                v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= accept;
            for (int k = 1; k < L; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg   <= ptrk_pkg::DIFF_W'(pos_x) - ptrk_pkg::DIFF_W'(seg.sx);
            dy_reg   <= ptrk_pkg::DIFF_W'(pos_y) - ptrk_pkg::DIFF_W'(seg.sy);
            ady_reg  <= seg.a * dy_reg;
            bdx_reg  <= seg.b * dx_reg;
            adx_reg  <= seg.a * dx_reg;
            bdy_reg  <= seg.b * dy_reg;
            numc_reg <= ptrk_pkg::NUM_W'(ady_reg) - ptrk_pkg::NUM_W'(bdx_reg);
            numa_reg <= ptrk_pkg::NUM_W'(adx_reg) + ptrk_pkg::NUM_W'(bdy_reg);
        end
    end

    ptrk_div u_div_cross (
        .clk (clk),
        .adv (adv),
        .num (numc_reg),
        .len (seg.len),
        .quo (quo_c)
    );

    ptrk_div u_div_along (
        .clk (clk),
        .adv (adv),
        .num (numa_reg),
        .len (seg.len),
        .quo (quo_a)
    );

    assign out_valid   = v_reg[L-1];
    assign degenerate  = seg.degen;
    assign cross_track = seg.degen ? '0 : quo_c;
    assign along_track = seg.degen ? '0 : quo_a;

endmodule

>>> rtl/ptrk_seg.sv
module ptrk_seg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ptrk_pkg::IDX_W-1:0]      cfg_index,
    input  logic [ptrk_pkg::COORD_W-1:0]    cfg_data,
    output ptrk_pkg::seg_t                  seg
);

    ptrk_pkg::seg_state_t state_reg, state_next;

    logic signed [ptrk_pkg::COORD_W-1:0] sx_reg, sy_reg, gx_reg, gy_reg;
    logic signed [ptrk_pkg::DIFF_W-1:0]  a, b;
    logic signed [ptrk_pkg::PROD_W-1:0]  asq_full, bsq_full;
    logic [ptrk_pkg::SQ_W-1:0]           asq_reg, bsq_reg;
    logic [ptrk_pkg::SUM_W-1:0]          s_reg, res_reg, bit_reg, trial;
    logic [ptrk_pkg::LEN_W-1:0]          len_reg;
    logic                                degen_reg;
    logic                                start;
    logic                                busy;

    assign a = ptrk_pkg::DIFF_W'(gx_reg) - ptrk_pkg::DIFF_W'(sx_reg);
    assign b = ptrk_pkg::DIFF_W'(gy_reg) - ptrk_pkg::DIFF_W'(sy_reg);
    assign asq_full = a * a;
    assign bsq_full = b * b;
    assign trial = res_reg + bit_reg;

    always_comb
    begin
        start = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                ptrk_pkg::REG_START_X, ptrk_pkg::REG_START_Y,
                ptrk_pkg::REG_GOAL_X, ptrk_pkg::REG_GOAL_Y: start = 1'b1;
                default: start = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptrk_pkg::SEG_IDLE:  state_next = ptrk_pkg::SEG_IDLE;
            ptrk_pkg::SEG_SQ:    state_next = ptrk_pkg::SEG_SUM;
            ptrk_pkg::SEG_SUM:   state_next = ptrk_pkg::SEG_ITER;
            ptrk_pkg::SEG_ITER:  state_next = bit_reg[0] ? ptrk_pkg::SEG_ROUND
                                                         : ptrk_pkg::SEG_ITER;
            ptrk_pkg::SEG_ROUND: state_next = ptrk_pkg::SEG_IDLE;
            default:             state_next = ptrk_pkg::SEG_IDLE;
        endcase
        if (start)
            state_next = ptrk_pkg::SEG_SQ;
    end

    always_comb
    begin
        busy = 1'b1;
        case (state_reg)
            ptrk_pkg::SEG_IDLE: busy = 1'b0;
            default:            busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptrk_pkg::SEG_IDLE;
            sx_reg    <= '0;
            sy_reg    <= '0;
            gx_reg    <= '0;
            gy_reg    <= '0;
            len_reg   <= '0;
            degen_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ptrk_pkg::REG_START_X: sx_reg <= cfg_data;
                    ptrk_pkg::REG_START_Y: sy_reg <= cfg_data;
                    ptrk_pkg::REG_GOAL_X:  gx_reg <= cfg_data;
                    ptrk_pkg::REG_GOAL_Y:  gy_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ptrk_pkg::SEG_ROUND && !start)
            begin
                len_reg   <= res_reg[ptrk_pkg::LEN_W-1:0]
                             + ptrk_pkg::LEN_W'(s_reg > res_reg);
                degen_reg <= (a == '0) && (b == '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ptrk_pkg::SEG_SQ:
            begin
                asq_reg <= asq_full[ptrk_pkg::SQ_W-1:0];
                bsq_reg <= bsq_full[ptrk_pkg::SQ_W-1:0];
            end
            ptrk_pkg::SEG_SUM:
            begin
                s_reg   <= ptrk_pkg::SUM_W'(asq_reg) + ptrk_pkg::SUM_W'(bsq_reg);
                res_reg <= '0;
                bit_reg <= ptrk_pkg::SUM_W'(1) << (ptrk_pkg::SUM_W - 2);
            end
            ptrk_pkg::SEG_ITER:
            begin
                if (s_reg >= trial)
                begin
                    s_reg   <= s_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        seg.busy  = busy;
        seg.degen = degen_reg;
        seg.len   = len_reg;
        seg.a     = a;
        seg.b     = b;
        seg.sx    = sx_reg;
        seg.sy    = sy_reg;
    end

endmodule

>>> rtl/ptrk_div.sv
module ptrk_div (
    input  logic                                clk,
    input  logic                                adv,
    input  logic signed [ptrk_pkg::NUM_W-1:0]   num,
    input  logic [ptrk_pkg::LEN_W-1:0]          len,
    output logic signed [ptrk_pkg::OUT_W-1:0]   quo
);

    localparam int N = ptrk_pkg::DIV_STAGES;

    logic [ptrk_pkg::REM_W-1:0] mag_reg;
    logic                       neg_reg [0:N+1];
    logic                       ovf_reg [0:N];
    logic [ptrk_pkg::REM_W-1:0] rem_reg [0:N];
    logic [ptrk_pkg::OUT_W-1:0] q_reg   [0:N];
    logic [ptrk_pkg::NUM_W-1:0] mag;
    logic [ptrk_pkg::REM_W-1:0] len_top;
    logic [ptrk_pkg::OUT_W-1:0] q_fin;
    logic signed [ptrk_pkg::OUT_W-1:0] quo_reg;

    assign mag = num[ptrk_pkg::NUM_W-1] ? ptrk_pkg::NUM_W'(-num) : ptrk_pkg::NUM_W'(num);
    assign len_top = ptrk_pkg::REM_W'(len) << N;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg    <= ptrk_pkg::REM_W'(mag) + ptrk_pkg::REM_W'(len >> 1);
            neg_reg[0] <= num[ptrk_pkg::NUM_W-1];
            neg_reg[1] <= neg_reg[0];
            ovf_reg[0] <= mag_reg >= len_top;
            rem_reg[0] <= mag_reg;
            q_reg[0]   <= '0;
        end
    end

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_stage
            logic [ptrk_pkg::REM_W-1:0] dvs;
            assign dvs = ptrk_pkg::REM_W'(len) << (N - 1 - i);
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    neg_reg[i+2] <= neg_reg[i+1];
                    ovf_reg[i+1] <= ovf_reg[i];
                    if (rem_reg[i] >= dvs)
                    begin
                        rem_reg[i+1] <= rem_reg[i] - dvs;
                        q_reg[i+1]   <= q_reg[i] | (ptrk_pkg::OUT_W'(1) << (N - 1 - i));
                    end
                    else
                    begin
                        rem_reg[i+1] <= rem_reg[i];
                        q_reg[i+1]   <= q_reg[i];
                    end
                end
            end
        end
    endgenerate

    assign q_fin = q_reg[N];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (neg_reg[N+1])
            begin
                if (ovf_reg[N] || q_fin > ptrk_pkg::OUT_W'(-ptrk_pkg::OUT_MIN))
                    quo_reg <= ptrk_pkg::OUT_MIN;
                else
                    quo_reg <= -$signed(q_fin);
            end
            else
            begin
                if (ovf_reg[N] || q_fin > ptrk_pkg::OUT_W'(ptrk_pkg::OUT_MAX))
                    quo_reg <= ptrk_pkg::OUT_MAX;
                else
                    quo_reg <= $signed(q_fin);
            end
        end
    end

    assign quo = quo_reg;

endmodule

>>> verif/path_line_tracking_error_top_tb.sv
module path_line_tracking_error_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [ptrk_pkg::COORD_W-1:0] x;
        logic signed [ptrk_pkg::COORD_W-1:0] y;
    } position_t;

    typedef struct {
        logic signed [ptrk_pkg::OUT_W-1:0] cross_track;
        logic signed [ptrk_pkg::OUT_W-1:0] along_track;
        logic                              degenerate;
    } track_err_t;

    localparam int POS_MAX = (1 << (ptrk_pkg::COORD_W - 1)) - 1;
    localparam int POS_MIN = -(1 << (ptrk_pkg::COORD_W - 1));

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [ptrk_pkg::IDX_W-1:0]          cfg_index;
    logic [ptrk_pkg::COORD_W-1:0]        cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    logic signed [ptrk_pkg::COORD_W-1:0] pos_x;
    logic signed [ptrk_pkg::COORD_W-1:0] pos_y;
    logic                                out_valid;
    logic                                out_stall;
    logic signed [ptrk_pkg::OUT_W-1:0]   cross_track;
    logic signed [ptrk_pkg::OUT_W-1:0]   along_track;
    logic                                degenerate;

    position_t  pending_pos[$];
    track_err_t expected_err[$];

    longint seg_sx, seg_sy, seg_gx, seg_gy;
    longint unsigned seg_len;

    int sent_count;
    int mismatch_count;
    int burst_left;
    int gap_left;
    int stall_pct;
    int stall_cycles;
    logic long_hold;

    path_line_tracking_error_top dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned round_sqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'h1 << 62;
        while (bitv > s)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (s >= r + bitv)
            begin
                s -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        if (s > r)
            r++;
        return r;
    endfunction

    function automatic logic signed [ptrk_pkg::OUT_W-1:0] div_round_sat(
        longint num, longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = (mag + (len >> 1)) / len;
        if (num < 0)
            return (q > 64'd33554432) ? ptrk_pkg::OUT_MIN
                                      : ptrk_pkg::OUT_W'(-longint'(q));
        return (q > 64'd33554431) ? ptrk_pkg::OUT_MAX : ptrk_pkg::OUT_W'(q);
    endfunction

    function automatic track_err_t predict_error(position_t p);
        track_err_t e;
        longint a, b, dx, dy;
        a = seg_gx - seg_sx;
        b = seg_gy - seg_sy;
        dx = longint'(p.x) - seg_sx;
        dy = longint'(p.y) - seg_sy;
        e.cross_track = '0;
        e.along_track = '0;
        e.degenerate = 1'b1;
        if (a != 0 || b != 0)
        begin
            e.degenerate = 1'b0;
            e.cross_track = div_round_sat(a * dy - b * dx, seg_len);
            e.along_track = div_round_sat(a * dx + b * dy, seg_len);
        end
        return e;
    endfunction

    task automatic write_reg(logic [ptrk_pkg::IDX_W-1:0] idx,
                             logic [ptrk_pkg::COORD_W-1:0] val);
        longint v;
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        v = longint'($signed(val));
        case (idx)
            ptrk_pkg::REG_START_X: seg_sx = v;
            ptrk_pkg::REG_START_Y: seg_sy = v;
            ptrk_pkg::REG_GOAL_X:  seg_gx = v;
            ptrk_pkg::REG_GOAL_Y:  seg_gy = v;
            default: return;
        endcase
        seg_len = round_sqrt(longint'((seg_gx - seg_sx) * (seg_gx - seg_sx))
                             + longint'((seg_gy - seg_sy) * (seg_gy - seg_sy)));
    endtask

    task automatic set_segment(int sx, int sy, int gx, int gy);
        write_reg(ptrk_pkg::REG_START_X, sx[ptrk_pkg::COORD_W-1:0]);
        write_reg(ptrk_pkg::REG_START_Y, sy[ptrk_pkg::COORD_W-1:0]);
        write_reg(ptrk_pkg::REG_GOAL_X, gx[ptrk_pkg::COORD_W-1:0]);
        write_reg(ptrk_pkg::REG_GOAL_Y, gy[ptrk_pkg::COORD_W-1:0]);
    endtask

    task automatic push_pos(int x, int y);
        position_t p;
        p.x = x[ptrk_pkg::COORD_W-1:0];
        p.y = y[ptrk_pkg::COORD_W-1:0];
        pending_pos.push_back(p);
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 9))
            0: return POS_MAX;
            1: return POS_MIN;
            2: return $urandom_range(0, 64) - 32;
            3: return $urandom_range(0, 4000) - 2000;
            default: return int'($signed($urandom() & 32'hFF_FFFF) <<< 8) >>> 8;
        endcase
    endfunction

    task automatic push_random(int n);
        repeat (n)
            push_pos(rand_coord(), rand_coord());
    endtask

    task automatic drain();
        wait (pending_pos.size() == 0 && !in_valid && expected_err.size() == 0);
        repeat (ptrk_pkg::LAT + 8) @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pos_x <= '0;
            pos_y <= '0;
            burst_left <= 4;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                position_t p;
                p.x = pos_x;
                p.y = pos_y;
                expected_err.push_back(predict_error(p));
                sent_count++;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_pos.size() > 0)
                begin
                    position_t p;
                    p = pending_pos.pop_front();
                    pos_x <= p.x;
                    pos_y <= p.y;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_pct <= 0;
            stall_cycles <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                track_err_t e;
                if (expected_err.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected transaction: cross %0d along %0d degen %0b",
                                 cross_track, along_track, degenerate);
                end
                else
                begin
                    e = expected_err.pop_front();
                    if (e.cross_track !== cross_track || e.along_track !== along_track
                        || e.degenerate !== degenerate)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
                                     e.cross_track, e.along_track, e.degenerate,
                                     cross_track, along_track, degenerate);
                    end
                end
            end
            if (stall_cycles == 0)
            begin
                stall_cycles <= $urandom_range(20, 120);
                case ($urandom_range(0, 3))
                    0: stall_pct <= 0;
                    1: stall_pct <= 20;
                    2: stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
            end
            else
                stall_cycles <= stall_cycles - 1;
            out_stall <= long_hold || ($urandom_range(0, 99) < stall_pct);
        end
    end

    // long receiver hold-off
    initial
    begin
        long_hold = 1'b0;
        wait (sent_count >= 300);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (200) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        #8ms;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sent_count = 0;
        mismatch_count = 0;
        seg_sx = 0;
        seg_sy = 0;
        seg_gx = 0;
        seg_gy = 0;
        seg_len = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // degenerate segment after reset
        push_pos(POS_MAX, POS_MIN);
        push_pos(0, 0);
        push_pos(-1, 1);
        drain();

        // longest segment, extreme positions
        set_segment(POS_MIN, POS_MIN, POS_MAX, POS_MAX);
        push_pos(POS_MAX, POS_MAX);
        push_pos(POS_MIN, POS_MIN);
        push_pos(POS_MAX, POS_MIN);
        push_pos(POS_MIN, POS_MAX);
        push_pos(0, 0);
        push_pos(-1, -1);
        drain();

        set_segment(POS_MAX, 0, POS_MIN, 0);
        push_pos(POS_MIN, POS_MAX);
        push_pos(POS_MAX, POS_MIN);
        push_pos(0, 1);
        push_random(100);
        drain();

        // unit length segment; index out of range must be ignored
        set_segment(0, 0, 1, 0);
        write_reg(3'd4, 24'h00_0100);
        write_reg(3'd7, 24'hFF_FFFF);
        push_pos(POS_MAX, POS_MAX);
        push_pos(POS_MIN, POS_MIN);
        push_pos(1, -1);
        push_random(100);
        drain();

        // start equals goal away from origin
        set_segment(-5000, 7000, -5000, 7000);
        push_pos(POS_MAX, 3);
        push_random(40);
        drain();

        set_segment(0, POS_MIN, 0, POS_MAX);
        push_random(100);
        drain();

        set_segment(3, -4, 6, 0);
        push_random(100);
        drain();

        repeat (6)
        begin
            set_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            push_random(85);
            drain();
        end

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
